>>> rtl/tgt_pkg.sv
// ----------------------------------------------------------------------------
// tgt_pkg
// Shared types and constants for the tachometer gauge tick core: controller
// states, command and status bundles, register codes and fixed tables.
// ----------------------------------------------------------------------------
package tgt_pkg;

   // quotient bits produced by the shared divider
   localparam int unsigned QUO_W = 17;
   // numerator width of the needle division: 16e6 * 375450 * 16 < 2**47
   localparam int unsigned NEEDLE_NUM_W = 47;
   // gear ratio coefficients are in thousandths and fit in 12 bits
   localparam int unsigned RATIO_W = 12;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 8;
   localparam int unsigned NEEDLE_W = 17;
   localparam int unsigned BACKLIGHT_W = 8;
   localparam int unsigned OFF_TIMER_W = 4;
   localparam int unsigned ZERO_TIMER_W = 9;

   // clock rate times the gauge scale factor, 16000000 * 375450
   localparam logic [NEEDLE_NUM_W-1:0] NEEDLE_SCALE = 47'd6007200000000;

   localparam logic [NEEDLE_W-1:0]    NEEDLE_MAX = 17'd125000;
   localparam logic [BACKLIGHT_W-1:0] BACKLIGHT_MAX = 8'd250;
   localparam logic [OFF_TIMER_W-1:0] OFF_TICKS = 4'd10;
   // largest light quotient whose times-four value stays below the clip level
   localparam logic [QUO_W-1:0]       LIGHT_QUO_MAX = 17'd62;

   localparam int unsigned SWITCH_THRESHOLD = 200;
   localparam int unsigned LIGHT_THRESHOLD = 200;
   localparam int unsigned OUTER_LOW = 338;
   localparam int unsigned OUTER_HIGH = 710;
   localparam int unsigned INNER_LOW = 346;
   localparam int unsigned INNER_HIGH = 691;

   // gear ratios in thousandths, upper entries repeat the last one
   localparam logic [RATIO_W-1:0] RATIO_MILLI [16] = '{
      12'd2080, 12'd2340, 12'd2400, 12'd2600, 12'd2900, 12'd3000, 12'd3200, 12'd3227,
      12'd3320, 12'd3700, 12'd4000, 12'd4075, 12'd4075, 12'd4075, 12'd4075, 12'd4075
   };

   // calibration needle positions, floor((250 + 250*i) * 37545 / 1000), clipped to NEEDLE_MAX
   localparam logic [NEEDLE_W-1:0] CAL_TARGET [16] = '{
      17'd9386,   17'd18772,  17'd28158,  17'd37545,
      17'd46931,  17'd56317,  17'd65703,  17'd75090,
      17'd84476,  17'd93862,  17'd103248, 17'd112635,
      17'd122021, 17'd125000, 17'd125000, 17'd125000
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RATIO_INDEX     = 2'd0,
      CSR_CALIBRATE_MODE  = 2'd1,
      CSR_ZERO_TIMEOUT    = 2'd2,
      CSR_CAPTURE_DIVIDER = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BL_START,
      ST_BL_WAIT,
      ST_WINDOW,
      ST_GATE,
      ST_MUL,
      ST_ND_START,
      ST_ND_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic {
      DIV_SEL_LIGHT,
      DIV_SEL_NEEDLE
   } div_sel_type;

   typedef struct packed {
      logic        load_input;
      logic        div_start;
      div_sel_type div_sel;
      logic        bl_update;
      logic        window_update;
      logic        timeout_step;
      logic        mul_load;
      logic        needle_direct;
      logic        needle_from_div;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic updates_enabled;
      logic needle_direct_ok;
   } status_type;

endpackage

>>> rtl/tgt_divider.sv
// ----------------------------------------------------------------------------
// tgt_divider
// Restoring divider, one quotient bit per cycle. An up-front compare flags
// quotients that do not fit in the quotient width, so callers can saturate.
// ----------------------------------------------------------------------------
module tgt_divider #(
   parameter int unsigned NUM_W = 47,
   parameter int unsigned DEN_W = 36
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [NUM_W-1:0]           num,
   input  logic [DEN_W-1:0]           den,
   output logic                       done,
   output logic                       overflow,
   output logic [tgt_pkg::QUO_W-1:0]  quotient
);

   localparam int unsigned QW = tgt_pkg::QUO_W;
   localparam int unsigned W = (NUM_W > DEN_W + QW) ? NUM_W : DEN_W + QW;
   localparam int unsigned CNT_W = $clog2(QW + 1);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     dsh_ff, dsh_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             ovf_ff, ovf_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [W-1:0] num_ext;
   logic [W-1:0] den_ext;
   logic         fits;

   assign num_ext = W'(num);
   assign den_ext = W'(den);
   assign fits = rem_ff >= dsh_ff;

   // start loads operands, then one compare and subtract per cycle
   always_comb begin
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = num_ext;
         dsh_in = den_ext << (QW - 1);
         quo_in = '0;
         cnt_in = CNT_W'(QW);
         ovf_in = num_ext >= (den_ext << QW);
         busy_in = !ovf_in;
         done_in = ovf_in;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - dsh_ff;
         end
         quo_in = {quo_ff[QW-2:0], fits};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      ovf_ff <= ovf_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign overflow = ovf_ff;
   assign quotient = quo_ff;

   // a new division never starts on top of a running one
   assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("divider started while busy");

   // the last step always reports completion
   assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !start && cnt_ff == CNT_W'(1)) |=> (done_ff && !busy_ff))
      else $error("divider missed its completion");

   // completion and activity are exclusive
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider done while busy");

endmodule

>>> rtl/tgt_datapath.sv
// ----------------------------------------------------------------------------
// tgt_datapath
// Gauge state, configuration registers, input and output registers and the
// arithmetic for backlight, ignition window, period timeout and needle target.
// ----------------------------------------------------------------------------
module tgt_datapath #(
   parameter int unsigned PERIOD_BITS = 24,
   parameter int unsigned RATIO_COUNT = 12,
   parameter int unsigned ADC_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tgt_pkg::cmd_type                     cmd,
   output tgt_pkg::status_type                  status,
   input  logic                                 csr_wr_en,
   input  logic [tgt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tgt_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic [ADC_BITS-1:0]                  req_light_level,
   input  logic [ADC_BITS-1:0]                  req_ignition_level,
   input  logic [ADC_BITS-1:0]                  req_demult_level,
   input  logic [ADC_BITS-1:0]                  req_divider_level,
   input  logic                                 req_capture_valid,
   input  logic [PERIOD_BITS-1:0]               req_period_count,
   output logic [tgt_pkg::NEEDLE_W-1:0]         rsp_needle_target,
   output logic [tgt_pkg::BACKLIGHT_W-1:0]      rsp_backlight_out,
   output logic                                 rsp_demult_out,
   output logic                                 rsp_divider_out,
   output logic                                 rsp_gauge_active,
   output logic                                 rsp_save_request
);

   localparam int unsigned NUM_W = tgt_pkg::NEEDLE_NUM_W;
   localparam int unsigned DEN_W = PERIOD_BITS + tgt_pkg::RATIO_W;
   localparam int unsigned NW = tgt_pkg::NEEDLE_W;
   localparam int unsigned BW = tgt_pkg::BACKLIGHT_W;
   localparam int unsigned OW = tgt_pkg::OFF_TIMER_W;
   localparam int unsigned ZW = tgt_pkg::ZERO_TIMER_W;
   localparam int unsigned QW = tgt_pkg::QUO_W;

   localparam logic [ADC_BITS-1:0] OUTER_LO = ADC_BITS'(tgt_pkg::OUTER_LOW);
   localparam logic [ADC_BITS-1:0] OUTER_HI = ADC_BITS'(tgt_pkg::OUTER_HIGH);
   localparam logic [ADC_BITS-1:0] INNER_LO = ADC_BITS'(tgt_pkg::INNER_LOW);
   localparam logic [ADC_BITS-1:0] INNER_HI = ADC_BITS'(tgt_pkg::INNER_HIGH);
   localparam logic [ADC_BITS-1:0] LIGHT_TH = ADC_BITS'(tgt_pkg::LIGHT_THRESHOLD);
   localparam logic [ADC_BITS-1:0] SWITCH_TH = ADC_BITS'(tgt_pkg::SWITCH_THRESHOLD);
   localparam logic [4:0]          RATIO_LIM = 5'(RATIO_COUNT);

   // configuration registers
   logic [3:0] ratio_idx_ff, ratio_idx_in;
   logic       cal_mode_ff, cal_mode_in;
   logic [7:0] zero_timeout_ff, zero_timeout_in;
   logic [3:0] cap_div_ff, cap_div_in;

   // gauge state
   logic [PERIOD_BITS-1:0] held_ff, held_in;
   logic                   seen_ff, seen_in;
   logic [ZW-1:0]          zero_timer_ff, zero_timer_in;
   logic [NW-1:0]          needle_ff, needle_in;
   logic [BW-1:0]          backlight_ff, backlight_in;
   logic                   enabled_ff, enabled_in;
   logic [OW-1:0]          off_timer_ff, off_timer_in;
   logic                   save_ff, save_in;

   // input transaction and division operands
   logic [ADC_BITS-1:0] light_ff, ign_ff, demult_ff, divider_ff;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [DEN_W-1:0]    den_ff, den_in;

   // output registers
   logic [NW-1:0] out_needle_ff;
   logic [BW-1:0] out_backlight_ff;
   logic          out_demult_ff, out_divider_ff, out_active_ff, out_save_ff;

   logic [3:0]          eff_idx;
   logic [NUM_W-1:0]    div_num;
   logic [DEN_W-1:0]    div_den;
   logic                div_done, div_ovf;
   logic [QW-1:0]       div_quo;
   logic [BW-1:0]       bl_goal;
   logic                in_outer, in_inner;
   logic [4:0]          div_plus;

   // out-of-range ratio index falls back to the first entry
   assign eff_idx = ({1'b0, ratio_idx_ff} >= RATIO_LIM) ? 4'd0 : ratio_idx_ff;
   assign div_plus = {1'b0, cap_div_ff} + 5'd1;

   // operand select for the shared divider
   always_comb begin
      case (cmd.div_sel)
         tgt_pkg::DIV_SEL_NEEDLE: begin
            div_num = num_ff;
            div_den = den_ff;
         end
         default: begin
            div_num = NUM_W'({light_ff, 5'b00000});
            div_den = DEN_W'(ign_ff);
         end
      endcase
   end

   tgt_divider #(
      .NUM_W(NUM_W),
      .DEN_W(DEN_W)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.div_start),
      .num     (div_num),
      .den     (div_den),
      .done    (div_done),
      .overflow(div_ovf),
      .quotient(div_quo)
   );

   // backlight goal from light over ignition, clipped; zero at or below the light threshold
   always_comb begin
      if (light_ff <= LIGHT_TH) begin
         bl_goal = '0;
      end else if (ign_ff == '0 || div_ovf || div_quo > tgt_pkg::LIGHT_QUO_MAX) begin
         bl_goal = tgt_pkg::BACKLIGHT_MAX;
      end else begin
         bl_goal = {div_quo[5:0], 2'b00};
      end
   end

   assign in_outer = (ign_ff > OUTER_LO) && (ign_ff < OUTER_HI);
   assign in_inner = (ign_ff > INNER_LO) && (ign_ff < INNER_HI);

   // configuration writes
   always_comb begin
      ratio_idx_in = ratio_idx_ff;
      cal_mode_in = cal_mode_ff;
      zero_timeout_in = zero_timeout_ff;
      cap_div_in = cap_div_ff;
      if (csr_wr_en) begin
         unique case (tgt_pkg::csr_index_type'(csr_index))
            tgt_pkg::CSR_RATIO_INDEX:     ratio_idx_in = csr_wr_data[3:0];
            tgt_pkg::CSR_CALIBRATE_MODE:  cal_mode_in = csr_wr_data[0];
            tgt_pkg::CSR_ZERO_TIMEOUT:    zero_timeout_in = csr_wr_data;
            tgt_pkg::CSR_CAPTURE_DIVIDER: cap_div_in = csr_wr_data[3:0];
            default: ;
         endcase
      end
   end

   // tick steps on the gauge state
   always_comb begin
      held_in = held_ff;
      seen_in = seen_ff;
      zero_timer_in = zero_timer_ff;
      needle_in = needle_ff;
      backlight_in = backlight_ff;
      enabled_in = enabled_ff;
      off_timer_in = off_timer_ff;
      save_in = save_ff;
      num_in = num_ff;
      den_in = den_ff;

      // capture latch
      if (cmd.load_input && req_capture_valid) begin
         held_in = req_period_count;
         seen_in = 1'b1;
      end

      // backlight ramp, one step per tick
      if (cmd.bl_update) begin
         if (bl_goal > backlight_ff) begin
            backlight_in = backlight_ff + BW'(1);
         end else if (bl_goal < backlight_ff) begin
            backlight_in = backlight_ff - BW'(1);
         end
      end

      // ignition window
      if (cmd.window_update) begin
         if (in_outer) begin
            if (in_inner) begin
               enabled_in = 1'b1;
               off_timer_in = '0;
            end
            save_in = 1'b1;
         end else if (off_timer_ff < tgt_pkg::OFF_TICKS) begin
            off_timer_in = off_timer_ff + OW'(1);
         end else begin
            needle_in = needle_ff >> 1;
            enabled_in = 1'b0;
         end
      end

      // period timeout
      if (cmd.timeout_step) begin
         if (zero_timer_ff > {1'b0, zero_timeout_ff}) begin
            if (!seen_ff) begin
               held_in = '0;
            end
            seen_in = 1'b0;
            zero_timer_in = '0;
         end else begin
            zero_timer_in = zero_timer_ff + ZW'(1);
         end
      end

      // division operands for the needle target
      if (cmd.mul_load) begin
         num_in = tgt_pkg::NEEDLE_SCALE * NUM_W'(div_plus);
         den_in = DEN_W'(held_ff) * DEN_W'(tgt_pkg::RATIO_MILLI[eff_idx]);
      end

      // needle target without division: calibration or no period
      if (cmd.needle_direct) begin
         needle_in = cal_mode_ff ? tgt_pkg::CAL_TARGET[eff_idx] : '0;
      end

      // needle target from the quotient, saturated
      if (cmd.needle_from_div) begin
         if (div_ovf || div_quo > tgt_pkg::NEEDLE_MAX) begin
            needle_in = tgt_pkg::NEEDLE_MAX;
         end else begin
            needle_in = div_quo;
         end
      end
   end

   // configuration and gauge state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_idx_ff <= '0;
         cal_mode_ff <= 1'b0;
         zero_timeout_ff <= 8'd50;
         cap_div_ff <= 4'd2;
         held_ff <= '0;
         seen_ff <= 1'b0;
         zero_timer_ff <= '0;
         needle_ff <= '0;
         backlight_ff <= '0;
         enabled_ff <= 1'b1;
         off_timer_ff <= '0;
         save_ff <= 1'b0;
      end else begin
         ratio_idx_ff <= ratio_idx_in;
         cal_mode_ff <= cal_mode_in;
         zero_timeout_ff <= zero_timeout_in;
         cap_div_ff <= cap_div_in;
         held_ff <= held_in;
         seen_ff <= seen_in;
         zero_timer_ff <= zero_timer_in;
         needle_ff <= needle_in;
         backlight_ff <= backlight_in;
         enabled_ff <= enabled_in;
         off_timer_ff <= off_timer_in;
         save_ff <= save_in;
      end
   end

   // transaction payload and operand registers
   always_ff @(posedge clock) begin
      if (cmd.load_input) begin
         light_ff <= req_light_level;
         ign_ff <= req_ignition_level;
         demult_ff <= req_demult_level;
         divider_ff <= req_divider_level;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      if (cmd.out_load) begin
         out_needle_ff <= needle_ff;
         out_backlight_ff <= backlight_ff;
         out_demult_ff <= demult_ff < SWITCH_TH;
         out_divider_ff <= divider_ff < SWITCH_TH;
         out_active_ff <= enabled_ff;
         out_save_ff <= save_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.updates_enabled = enabled_ff;
   assign status.needle_direct_ok = cal_mode_ff || (held_ff == '0);

   assign rsp_needle_target = out_needle_ff;
   assign rsp_backlight_out = out_backlight_ff;
   assign rsp_demult_out = out_demult_ff;
   assign rsp_divider_out = out_divider_ff;
   assign rsp_gauge_active = out_active_ff;
   assign rsp_save_request = out_save_ff;

endmodule

>>> rtl/tgt_ctrl.sv
// ----------------------------------------------------------------------------
// tgt_ctrl
// Tick sequencer: walks one transaction through backlight division, ignition
// window, period timeout and needle division, and owns the result valid.
// ----------------------------------------------------------------------------
module tgt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tgt_pkg::cmd_type     cmd,
   input  tgt_pkg::status_type  status
);

   tgt_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tgt_pkg::ST_IDLE: begin
            if (req_valid) state_in = tgt_pkg::ST_BL_START;
         end
         tgt_pkg::ST_BL_START: state_in = tgt_pkg::ST_BL_WAIT;
         tgt_pkg::ST_BL_WAIT: begin
            if (status.div_done) state_in = tgt_pkg::ST_WINDOW;
         end
         tgt_pkg::ST_WINDOW: state_in = tgt_pkg::ST_GATE;
         tgt_pkg::ST_GATE: begin
            state_in = status.updates_enabled ? tgt_pkg::ST_MUL : tgt_pkg::ST_DONE;
         end
         tgt_pkg::ST_MUL: begin
            state_in = status.needle_direct_ok ? tgt_pkg::ST_DONE : tgt_pkg::ST_ND_START;
         end
         tgt_pkg::ST_ND_START: state_in = tgt_pkg::ST_ND_WAIT;
         tgt_pkg::ST_ND_WAIT: begin
            if (status.div_done) state_in = tgt_pkg::ST_DONE;
         end
         tgt_pkg::ST_DONE: begin
            if (out_free) state_in = tgt_pkg::ST_IDLE;
         end
         default: state_in = tgt_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd = '0;
      cmd.div_sel = tgt_pkg::DIV_SEL_LIGHT;
      unique case (state_ff)
         tgt_pkg::ST_IDLE:     cmd.load_input = req_valid;
         tgt_pkg::ST_BL_START: cmd.div_start = 1'b1;
         tgt_pkg::ST_BL_WAIT:  cmd.bl_update = status.div_done;
         tgt_pkg::ST_WINDOW:   cmd.window_update = 1'b1;
         tgt_pkg::ST_GATE:     cmd.timeout_step = status.updates_enabled;
         tgt_pkg::ST_MUL: begin
            cmd.needle_direct = status.needle_direct_ok;
            cmd.mul_load = !status.needle_direct_ok;
         end
         tgt_pkg::ST_ND_START: begin
            cmd.div_start = 1'b1;
            cmd.div_sel = tgt_pkg::DIV_SEL_NEEDLE;
         end
         tgt_pkg::ST_ND_WAIT: begin
            cmd.div_sel = tgt_pkg::DIV_SEL_NEEDLE;
            cmd.needle_from_div = status.div_done;
         end
         tgt_pkg::ST_DONE:     cmd.out_load = out_free;
         default: ;
      endcase
   end

   // result valid: set on load, cleared once taken
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tgt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != tgt_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // a result never overwrites one that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten");

   // state updates from the divider only on its completion
   assert property (@(posedge clock) disable iff (reset)
      (cmd.bl_update || cmd.needle_from_div) |-> status.div_done)
      else $error("quotient used before division finished");

   // an accepted transaction always starts with the backlight division
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == tgt_pkg::ST_BL_START))
      else $error("accepted transaction not started");

endmodule

>>> rtl/tachometer_gauge_tick_core.sv
// ----------------------------------------------------------------------------
// tachometer_gauge_tick_core
// One gauge tick per transaction: ADC readings and the newest capture period
// in, needle target, backlight level and switch and window flags out.
// ----------------------------------------------------------------------------
// A tick is longest when both divisions run all 17 steps, shorter when the
// needle target needs no division, and shortest when the backlight quotient
// overflows and needle updates are off. Its length is set by one shared
// 17-step restoring divider, which runs once for the backlight ratio and,
// while needle updates are enabled and a period is held outside calibrate
// mode, once more for the needle target; a quotient too large to fit ends
// its division at the start, with no steps run. A new tick is accepted in
// the cycle after the previous one has moved into the result register,
// even while that result still waits. Configuration writes go to csr_index
// 0..3 (ratio index, calibrate mode, zero timeout, capture divider); the
// user must make them only while no tick is in flight, as the block does
// not enforce it.
module tachometer_gauge_tick_core #(
   parameter int unsigned PERIOD_BITS = 24,
   parameter int unsigned RATIO_COUNT = 12,
   parameter int unsigned ADC_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [tgt_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [tgt_pkg::CSR_DATA_W-1:0]       csr_wr_data,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [ADC_BITS-1:0]                  req_light_level,
   input  logic [ADC_BITS-1:0]                  req_ignition_level,
   input  logic [ADC_BITS-1:0]                  req_demult_level,
   input  logic [ADC_BITS-1:0]                  req_divider_level,
   input  logic                                 req_capture_valid,
   input  logic [PERIOD_BITS-1:0]               req_period_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [tgt_pkg::NEEDLE_W-1:0]         rsp_needle_target,
   output logic [tgt_pkg::BACKLIGHT_W-1:0]      rsp_backlight_out,
   output logic                                 rsp_demult_out,
   output logic                                 rsp_divider_out,
   output logic                                 rsp_gauge_active,
   output logic                                 rsp_save_request
);

   tgt_pkg::cmd_type    cmd;
   tgt_pkg::status_type status;

   // tick sequencer
   tgt_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd),
      .status   (status)
   );

   // gauge arithmetic and state
   tgt_datapath #(
      .PERIOD_BITS(PERIOD_BITS),
      .RATIO_COUNT(RATIO_COUNT),
      .ADC_BITS   (ADC_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_light_level   (req_light_level),
      .req_ignition_level(req_ignition_level),
      .req_demult_level  (req_demult_level),
      .req_divider_level (req_divider_level),
      .req_capture_valid (req_capture_valid),
      .req_period_count  (req_period_count),
      .rsp_needle_target (rsp_needle_target),
      .rsp_backlight_out (rsp_backlight_out),
      .rsp_demult_out    (rsp_demult_out),
      .rsp_divider_out   (rsp_divider_out),
      .rsp_gauge_active  (rsp_gauge_active),
      .rsp_save_request  (rsp_save_request)
   );

endmodule
